>>> rtl/rdm_pkg.sv
`timescale 1ns / 1ps

package rdm_pkg;

   // request codes
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_TEXT   = 2'd1;
   localparam logic [1:0] REQ_END    = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // special pattern bytes
   localparam logic [7:0] CH_ANY   = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_BLANK = 8'h20;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } rsp_payload_type;

   // handed from one column cell to the next
   typedef struct packed {
      logic go;      // sweep token
      logic match;   // new bit of this column
      logic old;     // bit of this column before the update
      logic lnew;    // new bit of the column to the left
   } rdm_link_type;

endpackage

>>> rtl/regex_dot_star_matcher_unit.sv
`timescale 1ns / 1ps
// Every transaction starts a sweep of a token down MAX_PATTERN+1 column cells, one per cycle.
// An item occupies the block until its token leaves the last cell; the next request can be
// taken in that cycle at the earliest, and an end request also waits for a pending result.
// An end result is registered at acceptance and shown the next cycle. After reset the row
// is armed by one sweep, during which no request is taken.
module regex_dot_star_matcher_unit #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rdm_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rdm_pkg::rsp_payload_type rsp_payload
);

   localparam int NCELL = MAX_PATTERN + 1;
   localparam int LW    = $clog2(MAX_PATTERN + 1);

   logic [7:0]    pat_ff [MAX_PATTERN];
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic          busy_ff, busy_in;
   logic          start_ff, start_in;
   logic          arm_ff, arm_in;
   logic [7:0]    c_ff, c_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rdm_pkg::rsp_payload_type rsp_ff;

   rdm_pkg::rdm_link_type link [NCELL+1];
   logic [NCELL-1:0]      row;
   logic                  last_go;
   logic                  req_accept;
   logic                  is_end;
   logic                  room;

   assign last_go    = link[NCELL].go;
   assign is_end     = (req_payload.req_type == rdm_pkg::REQ_END);
   assign req_ready  = (!busy_ff || last_go) && (!rsp_valid_ff || rsp_ready || !is_end);
   assign req_accept = req_valid && req_ready;
   assign room       = (len_ff != LW'(MAX_PATTERN));

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff && !last_go;
      start_in     = 1'b0;
      arm_in       = arm_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         busy_in  = 1'b1;
         start_in = 1'b1;
         arm_in   = (req_payload.req_type != rdm_pkg::REQ_TEXT);
         c_in     = arm_in ? rdm_pkg::CH_BLANK : req_payload.symbol;
         unique case (req_payload.req_type)
            rdm_pkg::REQ_APPEND: begin
               if (room) begin
                  len_in = len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            rdm_pkg::REQ_TEXT: begin
            end
            rdm_pkg::REQ_END: begin
               rsp_valid_in = 1'b1;
            end
            rdm_pkg::REQ_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         busy_ff      <= 1'b1;
         start_ff     <= 1'b1;
         arm_ff       <= 1'b1;
         c_ff         <= rdm_pkg::CH_BLANK;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         arm_ff       <= arm_in;
         c_ff         <= c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pattern bytes and the end result need no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (req_accept && req_payload.req_type == rdm_pkg::REQ_APPEND &&
             len_ff == LW'(k)) begin
            pat_ff[k] <= req_payload.symbol;
         end
      end
      if (req_accept && is_end) begin
         rsp_ff.matched  <= row[len_ff];
         rsp_ff.overflow <= ovf_ff;
      end
   end

   // column zero: never matches after arming, seeds the start row while arming
   assign link[0].go    = start_ff;
   assign link[0].match = 1'b0;
   assign link[0].old   = arm_ff;
   assign link[0].lnew  = 1'b0;

   for (genvar g = 0; g < NCELL; g++) begin : g_col
      logic [7:0] pc;
      logic [7:0] pp;
      logic       active;

      if (g == 0) begin : g_pc0
         assign pc = rdm_pkg::CH_BLANK;
      end else begin : g_pcn
         assign pc = pat_ff[g-1];
      end
      if (g <= 1) begin : g_pp0
         assign pp = rdm_pkg::CH_BLANK;
      end else begin : g_ppn
         assign pp = pat_ff[g-2];
      end
      assign active = (len_ff >= LW'(g));

      rdm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link[g]),
         .link_out (link[g+1]),
         .active   (active),
         .arm      (arm_ff),
         .c        (c_ff),
         .pc       (pc),
         .pp       (pp)
      );

      assign row[g] = link[g+1].match;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/rdm_cell.sv
`timescale 1ns / 1ps

module rdm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  rdm_pkg::rdm_link_type link_in,
   output rdm_pkg::rdm_link_type link_out,
   input  logic                 active,
   input  logic                 arm,
   input  logic [7:0]           c,
   input  logic [7:0]           pc,
   input  logic [7:0]           pp
);

   logic go_ff;
   logic match_ff, match_in;
   logic old_ff;
   logic lnew_ff;
   logic prev_bit;
   logic hit;
   logic pp_hit;

   always_comb begin
      // arming starts from an empty row
      prev_bit = arm ? 1'b0 : match_ff;
      hit      = (c == pc) || (pc == rdm_pkg::CH_ANY);
      pp_hit   = (c == pp) || (pp == rdm_pkg::CH_ANY);
      priority if (hit) begin
         match_in = link_in.old;
      end else if (pc == rdm_pkg::CH_STAR) begin
         match_in = pp_hit ? (link_in.match | link_in.lnew | prev_bit) : link_in.lnew;
      end else begin
         match_in = 1'b0;
      end
      match_in = match_in & active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= link_in.go;
      end
   end

   always_ff @(posedge clock) begin
      if (link_in.go) begin
         match_ff <= match_in;
         old_ff   <= prev_bit;
         lnew_ff  <= link_in.match;
      end
   end

   assign link_out.go    = go_ff;
   assign link_out.match = match_ff;
   assign link_out.old   = old_ff;
   assign link_out.lnew  = lnew_ff;

endmodule
